// File: rtl/core/lmu_pkg.sv
// Package for the lattice Metropolis update block: field widths, op and
// register codes, fixed-point constants and the reciprocal table.
// No dependencies.
`default_nettype none
package lmu_pkg;

  localparam int NT_DEFAULT = 16;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] REG_STEP_SIZE  = 2'd0;
  localparam logic [1:0] REG_QUAD_COEFF = 2'd1;
  localparam logic [1:0] REG_QUART_COEFF = 2'd2;

  localparam logic [15:0]        STEP_SIZE_RESET = 16'd18678;
  localparam logic signed [23:0] QUAD_RESET      = 24'sd65536;
  localparam logic signed [23:0] QUART_RESET     = 24'sd65536;

  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam logic [3:0]  TAYLOR_TERMS = 4'd14;
  localparam logic signed [55:0] FLUSH_LIMIT = 56'sd726817;
  localparam logic signed [25:0] MAX24 = 26'sd8388607;
  localparam logic signed [25:0] MIN24 = -26'sd8388608;
  localparam logic signed [24:0] TWO_Q16 = 25'sd131072;

  typedef struct packed {
    logic [15:0]        step_size;
    logic signed [23:0] quadratic_coeff;
    logic signed [23:0] quartic_coeff;
  } cfg_t;

  // floor(2^33 / k) for the rounded division by a Taylor index
  function automatic logic [33:0] recip(input logic [3:0] k);
    logic [33:0] r;
    case (k)
      4'd2:    r = 34'd4294967296;
      4'd3:    r = 34'd2863311530;
      4'd4:    r = 34'd2147483648;
      4'd5:    r = 34'd1717986918;
      4'd6:    r = 34'd1431655765;
      4'd7:    r = 34'd1227133513;
      4'd8:    r = 34'd1073741824;
      4'd9:    r = 34'd954437176;
      4'd10:   r = 34'd858993459;
      4'd11:   r = 34'd780903144;
      4'd12:   r = 34'd715827882;
      4'd13:   r = 34'd660764199;
      4'd14:   r = 34'd613566756;
      default: r = 34'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/lmu_req_if.sv
// Request channel of the lattice update block: op, site and draws.
// No dependencies.
`default_nettype none
interface lmu_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [3:0]         site_index;
  logic signed [23:0] load_value;
  logic signed [15:0] step_draw;
  logic [15:0]        accept_draw;
  modport source (output valid, op, site_index, load_value, step_draw, accept_draw,
                  input ready);
  modport sink (input valid, op, site_index, load_value, step_draw, accept_draw,
                output ready);
endinterface
`default_nettype wire

// File: rtl/core/lmu_rsp_if.sv
// Response channel of the lattice update block: accept flag and site value.
// No dependencies.
`default_nettype none
interface lmu_rsp_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic signed [23:0] site_value;
  modport source (output valid, accepted, site_value, input ready);
  modport sink (input valid, accepted, site_value, output ready);
endinterface
`default_nettype wire

// File: rtl/core/lmu_cfg_if.sv
// Configuration write channel of the lattice update block.
// No dependencies.
`default_nettype none
interface lmu_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/lmu_ram.sv
// Lattice site store: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module lmu_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic signed [23:0]   wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic signed [23:0]        rdata
);
  logic signed [23:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/core/lmu_core.sv
// Sequencer and datapath of the lattice update: one shared multiplier,
// action change, Taylor exponential and result register.
// Depends on lmu_pkg, lmu_req_if, lmu_rsp_if; drives lmu_ram.
`default_nettype none
module lmu_core #(
  parameter int NT = lmu_pkg::NT_DEFAULT,
  parameter int AW = $clog2(NT)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  lmu_req_if.sink            req,
  lmu_rsp_if.source          rsp,
  input  wire lmu_pkg::cfg_t cfg,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic signed [23:0] ram_wdata,
  output logic [AW-1:0]      ram_raddr,
  input  wire logic signed [23:0] ram_rdata
);
  localparam logic [4:0] S_IDLE = 5'd0,  S_RDW = 5'd1,  S_U1 = 5'd2,  S_U2 = 5'd3,
                         S_U3 = 5'd4,   S_U4 = 5'd5,   S_U5 = 5'd6,  S_U6 = 5'd7,
                         S_U7 = 5'd8,   S_U8 = 5'd9,   S_U9 = 5'd10, S_U10 = 5'd11,
                         S_DEC = 5'd12, H_A = 5'd13,   H_B = 5'd14,  H_C = 5'd15,
                         P_A = 5'd16,   P_B = 5'd17,   S_WB = 5'd18, S_DONE = 5'd19;

  logic [4:0]         state;
  logic [1:0]         op_r;
  logic [AW-1:0]      idx_r, up_idx, lo_idx, req_idx;
  logic signed [15:0] step_draw_r;
  logic [15:0]        accept_draw_r;
  logic signed [23:0] x, u, xn, res_val;
  logic signed [24:0] upl;
  logic [30:0]        x2o, x2n;
  logic [44:0]        x4o;
  logic signed [29:0] h;
  logic [15:0]        low;
  logic signed [55:0] d;
  logic [30:0]        hf, f_frac, t, qq, r, e1;
  logic [3:0]         k, cnt;
  logic               e1_valid, e1_mode, acc;
  logic               out_valid, out_acc, out_load;
  logic signed [23:0] out_val;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;

  // combinational helpers
  logic signed [67:0] p_rnd15, p_rnd16;
  logic [67:0]        p_rnd30;
  logic signed [25:0] xn_sum;
  logic signed [23:0] xn_sat;
  logic [44:0]        x4n;
  logic signed [45:0] dq4;
  logic [30:0]        q, qq_c, est, qv;
  logic [34:0]        est_k;
  logic signed [55:0] a_neg;
  logic [19:0]        a;
  logic [16:0]        e_q16;

  function automatic logic signed [55:0] rnd16(input logic signed [67:0] v);
    logic signed [67:0] tmp;
    tmp = v + 68'sd32768;
    return 56'(tmp >>> 16);
  endfunction

  // reduce a site index modulo NT through a constant lookup over the index codes
  function automatic logic [AW-1:0] site_mod(input logic [3:0] s);
    logic [AW-1:0] m;
    m = '0;
    for (int i = 0; i < 16; i++) begin
      if (s == 4'(i)) m = AW'(i % NT);
    end
    return m;
  endfunction

  assign req_idx = site_mod(req.site_index);
  assign up_idx  = (idx_r == AW'(NT - 1)) ? '0 : idx_r + 1'b1;
  assign lo_idx  = (idx_r == '0) ? AW'(NT - 1) : idx_r - 1'b1;

  assign p_rnd15 = (prod + 68'sd16384) >>> 15;
  assign p_rnd16 = (prod + 68'sd32768) >>> 16;
  assign p_rnd30 = 68'(prod) + 68'h2000_0000;
  assign xn_sum  = 26'(x) + 26'(p_rnd15);
  assign xn_sat  = (xn_sum > lmu_pkg::MAX24) ? 24'sh7FFFFF :
                   (xn_sum < lmu_pkg::MIN24) ? 24'sh800000 : xn_sum[23:0];
  assign x4n     = p_rnd16[44:0];
  assign dq4     = $signed({1'b0, x4o}) - $signed({1'b0, x4n});
  assign q       = p_rnd30[60:30];
  assign qq_c    = q + 31'(k >> 1);
  assign est     = prod[63:33];
  assign est_k   = 35'(est) * 35'(k);
  assign qv      = ((35'(qq) - est_k) >= 35'(k)) ? est + 1'b1 : est;
  assign a_neg   = -d;
  assign a       = a_neg[19:0];
  assign e_q16   = 17'((32'(r) + 32'h2000) >> 14);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_U1: begin
        mul_a = 34'(step_draw_r);
        mul_b = $signed({18'd0, cfg.step_size});
      end
      S_U2: begin
        mul_a = 34'(x);
        mul_b = 34'(x);
      end
      S_U3: begin
        mul_a = 34'(xn);
        mul_b = 34'(xn);
      end
      S_U4: begin
        mul_a = $signed({3'd0, x2o});
        mul_b = $signed({3'd0, x2o});
      end
      S_U5: begin
        mul_a = $signed({3'd0, x2n});
        mul_b = $signed({3'd0, x2n});
      end
      S_U6: begin
        mul_a = 34'(lmu_pkg::TWO_Q16 + 25'(cfg.quadratic_coeff));
        mul_b = $signed({3'd0, x2o}) - $signed({3'd0, x2n});
      end
      S_U7: begin
        mul_a = 34'(cfg.quartic_coeff);
        mul_b = 34'(h);
      end
      S_U8: begin
        mul_a = 34'(cfg.quartic_coeff);
        mul_b = $signed({18'd0, low});
      end
      S_U9: begin
        mul_a = 34'(upl) <<< 1;
        mul_b = 34'(x) - 34'(xn);
        mul_b = -mul_b;
      end
      H_A: begin
        mul_a = $signed({3'd0, hf});
        mul_b = $signed({3'd0, t});
      end
      H_B: begin
        mul_a = $signed({3'd0, qq_c});
        mul_b = $signed(lmu_pkg::recip(k));
      end
      P_A: begin
        mul_a = $signed({3'd0, r});
        mul_b = $signed({3'd0, e1});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // site store read address: x, then the upper and lower neighbors
  always_comb begin
    ram_raddr = req_idx;
    if (state == S_U1) ram_raddr = up_idx;
    if (state == S_U2) ram_raddr = lo_idx;
  end

  // the store is written either by a load transfer in idle or on write-back;
  // reads of that entry come only in a later state, so no forwarding
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = xn;
    if (state == S_IDLE && req.valid && req.op == lmu_pkg::OP_LOAD) begin
      ram_we    = 1'b1;
      ram_waddr = req_idx;
      ram_wdata = req.load_value;
    end else if (state == S_WB && acc) begin
      ram_we = 1'b1;
    end
  end

  assign req.ready    = (state == S_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.accepted = out_acc;
  assign rsp.site_value = out_val;

  // load the output register when it is empty or drains in this cycle
  assign out_load = (state == S_DONE) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      e1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_r          <= req.op;
            idx_r         <= req_idx;
            step_draw_r   <= req.step_draw;
            accept_draw_r <= req.accept_draw;
            acc           <= 1'b0;
            case (req.op)
              lmu_pkg::OP_LOAD: begin
                res_val <= req.load_value;
                state   <= S_DONE;
              end
              lmu_pkg::OP_UPDATE: state <= S_U1;
              default: state <= S_RDW;
            endcase
          end
        end
        S_RDW: begin
          res_val <= ram_rdata;
          state   <= S_DONE;
        end
        S_U1: begin
          x     <= ram_rdata;
          state <= S_U2;
        end
        S_U2: begin
          u     <= ram_rdata;
          xn    <= xn_sat;
          state <= S_U3;
        end
        S_U3: begin
          upl   <= 25'(u) + 25'(ram_rdata);
          x2o   <= p_rnd16[30:0];
          state <= S_U4;
        end
        S_U4: begin
          x2n   <= p_rnd16[30:0];
          state <= S_U5;
        end
        S_U5: begin
          x4o   <= p_rnd16[44:0];
          state <= S_U6;
        end
        S_U6: begin
          h     <= dq4[45:16];
          low   <= dq4[15:0];
          state <= S_U7;
        end
        S_U7: begin
          d     <= rnd16(prod);
          state <= S_U8;
        end
        S_U8: begin
          d     <= d + 56'(prod);
          state <= S_U9;
        end
        S_U9: begin
          d     <= d + rnd16(prod);
          state <= S_U10;
        end
        S_U10: begin
          d     <= d + rnd16(prod);
          state <= S_DEC;
        end
        S_DEC: begin
          if (!d[55]) begin
            acc   <= 1'b1;
            state <= S_WB;
          end else if (d < -lmu_pkg::FLUSH_LIMIT) begin
            acc   <= (accept_draw_r == 16'd0);
            state <= S_WB;
          end else begin
            f_frac  <= {1'b0, a[15:0], 14'd0};
            cnt     <= a[19:16];
            t       <= lmu_pkg::Q30_ONE;
            k       <= lmu_pkg::TAYLOR_TERMS;
            hf      <= e1_valid ? {1'b0, a[15:0], 14'd0} : lmu_pkg::Q30_ONE;
            e1_mode <= !e1_valid;
            state   <= H_A;
          end
        end
        H_A: state <= H_B;
        H_B: begin
          qq <= qq_c;
          if (k == 4'd1) begin
            // last Horner term: division by one is the value itself
            if (e1_mode) begin
              e1       <= lmu_pkg::Q30_ONE - q;
              e1_valid <= 1'b1;
              e1_mode  <= 1'b0;
              hf       <= f_frac;
              t        <= lmu_pkg::Q30_ONE;
              k        <= lmu_pkg::TAYLOR_TERMS;
              state    <= H_A;
            end else begin
              r     <= lmu_pkg::Q30_ONE - q;
              state <= P_A;
            end
          end else begin
            state <= H_C;
          end
        end
        H_C: begin
          t     <= lmu_pkg::Q30_ONE - qv;
          k     <= k - 1'b1;
          state <= H_A;
        end
        P_A: begin
          if (cnt == 4'd0) begin
            acc   <= ({1'b0, accept_draw_r} <= e_q16);
            state <= S_WB;
          end else begin
            state <= P_B;
          end
        end
        P_B: begin
          r     <= p_rnd30[60:30];
          cnt   <= cnt - 1'b1;
          state <= P_A;
        end
        S_WB: begin
          res_val <= acc ? xn : x;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_acc   <= acc;
            out_val   <= res_val;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_horner_k: assert property (@(posedge clk) disable iff (rst)
    (state == H_A) |-> (k != 4'd0 && t <= lmu_pkg::Q30_ONE))
    else $error("Horner step with bad index or term");
  a_pow_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == P_B) |-> (cnt != 4'd0 && e1_valid))
    else $error("power step without count or e^-1");
  a_no_acc: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && op_r != lmu_pkg::OP_UPDATE) |-> !acc)
    else $error("load or read flagged accepted");
  a_wb_busy: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != S_IDLE) |-> (state == S_WB && op_r == lmu_pkg::OP_UPDATE))
    else $error("site write outside write-back");
endmodule
`default_nettype wire

// File: rtl/core/lattice_metropolis_update_top.sv
// Top level of the lattice Metropolis update block: configuration registers,
// site store and the update sequencer.
// Depends on lmu_pkg, lmu_req_if, lmu_rsp_if, lmu_cfg_if, lmu_ram, lmu_core.
//
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | op, site_index, load_value, step_draw, accept_draw
//  rsp     | out | valid/ready  | accepted, site_value
//  cfg     | in  | valid/ready  | index, data (step_size, quadratic_coeff, quartic_coeff)
//
// One item at a time. A load answers straight from the request, a read from the
// site store. An update reads x and both neighbors from the single read port and
// forms the action change on the one shared multiplier; a negative change that is
// not flushed adds the 14-term Taylor series plus a multiplication by e^-1 per
// whole unit of the change (up to 11); the first after reset also builds e^-1.
// Reset (rst, synchronous) restores the registers; lattice contents are undefined
// until loaded. A finished result waits in the output register while the next
// transfer is accepted; cfg is always ready.
`default_nettype none
module lattice_metropolis_update_top #(
  parameter int NT = lmu_pkg::NT_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  lmu_req_if.sink   req,
  lmu_rsp_if.source rsp,
  lmu_cfg_if.sink   cfg
);
  localparam int AW = (NT > 1) ? $clog2(NT) : 1;

  lmu_pkg::cfg_t      cfg_regs;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic signed [23:0] ram_wdata, ram_rdata;

  assign cfg.ready = 1'b1;

  // hold register values; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.step_size       <= lmu_pkg::STEP_SIZE_RESET;
      cfg_regs.quadratic_coeff <= lmu_pkg::QUAD_RESET;
      cfg_regs.quartic_coeff   <= lmu_pkg::QUART_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        lmu_pkg::REG_STEP_SIZE:   cfg_regs.step_size       <= cfg.data[15:0];
        lmu_pkg::REG_QUAD_COEFF:  cfg_regs.quadratic_coeff <= $signed(cfg.data);
        lmu_pkg::REG_QUART_COEFF: cfg_regs.quartic_coeff   <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

  lmu_ram #(.DEPTH(NT), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lmu_core #(.NT(NT), .AW(AW)) u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg       (cfg_regs),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );
endmodule
`default_nettype wire

// File: sim/lmu_tb_if.sv
`timescale 1ns / 1ps
// Testbench-side item types of the lattice update channels; the block's own
// interface files (lmu_req_if, lmu_rsp_if, lmu_cfg_if) carry the signals.
// No dependencies.
package lmu_tb_pkg;

  // op code with no function of its own; the block treats it as a read
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         site_index;
    logic signed [23:0] load_value;
    logic signed [15:0] step_draw;
    logic [15:0]        accept_draw;
  } site_req_t;

  typedef struct packed {
    logic               accepted;
    logic signed [23:0] site_value;
  } site_rsp_t;
endpackage

// File: sim/lattice_metropolis_update_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lattice_metropolis_update_top: random and directed
// load, update and read transfers checked against a fixed-point lattice predictor.
// Depends on lmu_pkg, lmu_tb_pkg, the channel interfaces and the block itself.
module lattice_metropolis_update_top_tb;

  localparam int SITES = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lmu_req_if req ();
  lmu_rsp_if rsp ();
  lmu_cfg_if cfg ();

  lattice_metropolis_update_top #(.NT(SITES)) dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  // Predictor state: own copy of the lattice and registers
  logic signed [23:0] site_mem [SITES];
  logic [15:0]        pr_step;
  logic signed [23:0] pr_quad;
  logic signed [23:0] pr_quart;

  lmu_tb_pkg::site_req_t pending_q [$];
  lmu_tb_pkg::site_rsp_t expected_q [$];
  int  mismatches = 0;
  int  n_results = 0;
  int  n_accepts = 0;
  int  n_updates = 0;
  bit  quiet = 1'b0;     // turn idling off for a stretch
  bit  stim_done = 1'b0;

  // floor division by 2^s, signed
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round16(longint v);
    return floor_shr(v + 32768, 16);
  endfunction

  // e^-f, f in Q30 within [0, 1.0], Horner Taylor series, result Q30
  function automatic longint taylor_exp(longint f);
    longint t;
    longint q;
    t = longint'(1) << 30;
    for (int k = 14; k >= 1; k--) begin
      q = (f * t + (longint'(1) << 29)) >>> 30;
      q = (q + k / 2) / k;
      t = (longint'(1) << 30) - q;
    end
    return t;
  endfunction

  function automatic longint boltzmann_q16(longint d);
    longint a, n, r, e1;
    if (d < -726817) return 0;
    a = -d;
    n = a >>> 16;
    r = taylor_exp((a & 16'hFFFF) << 14);
    e1 = taylor_exp(longint'(1) << 30);
    for (longint i = 0; i < n; i++) r = (r * e1 + (longint'(1) << 29)) >>> 30;
    return (r + (longint'(1) << 13)) >>> 14;
  endfunction

  // Apply one request to the predicted lattice and return the response
  function automatic lmu_tb_pkg::site_rsp_t predict_site(lmu_tb_pkg::site_req_t it);
    lmu_tb_pkg::site_rsp_t o;
    int idx, up, lo;
    longint x, xn, p, x2o, x2n, dq4, h, lw, d;
    idx = it.site_index;
    o.accepted = 1'b0;
    if (it.op == lmu_pkg::OP_LOAD) begin
      site_mem[idx] = it.load_value;
    end else if (it.op == lmu_pkg::OP_UPDATE) begin
      up = (idx + 1) % SITES;
      lo = (idx + SITES - 1) % SITES;
      x = site_mem[idx];
      p = longint'(it.step_draw) * longint'(pr_step);
      xn = x + floor_shr(p + 16384, 15);
      if (xn > 8388607) xn = 8388607;
      if (xn < -8388608) xn = -8388608;
      x2o = (x * x + 32768) >>> 16;
      x2n = (xn * xn + 32768) >>> 16;
      dq4 = ((x2o * x2o + 32768) >>> 16) - ((x2n * x2n + 32768) >>> 16);
      h = floor_shr(dq4, 16);
      lw = dq4 - h * 65536;
      d = round16((longint'(131072) + longint'(pr_quad)) * (x2o - x2n));
      d += longint'(pr_quart) * h + round16(longint'(pr_quart) * lw);
      d += round16(2 * (longint'(site_mem[up]) + longint'(site_mem[lo])) * (xn - x));
      if (d >= 0) o.accepted = 1'b1;
      else o.accepted = (longint'(it.accept_draw) <= boltzmann_q16(d));
      if (o.accepted) site_mem[idx] = 24'(xn);
    end
    o.site_value = site_mem[idx];
    return o;
  endfunction

  // Driver: present pending items, advance on transfer
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= 37)) begin
        lmu_tb_pkg::site_req_t it;
        it = pending_q.pop_front();
        expected_q = {expected_q, predict_site(it)};
        if (it.op == lmu_pkg::OP_UPDATE) n_updates++;
        req.valid       <= 1'b1;
        req.op          <= it.op;
        req.site_index  <= it.site_index;
        req.load_value  <= it.load_value;
        req.step_draw   <= it.step_draw;
        req.accept_draw <= it.accept_draw;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each response transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        lmu_tb_pkg::site_rsp_t e;
        n_results++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response acc=%0b val=%0d",
                                         rsp.accepted, rsp.site_value);
        end else begin
          e = expected_q.pop_front();
          if (e.accepted) n_accepts++;
          if (e.accepted !== rsp.accepted || e.site_value !== rsp.site_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("response mismatch: exp acc=%0b val=%0d, got acc=%0b val=%0d",
                       e.accepted, e.site_value, rsp.accepted, rsp.site_value);
          end
        end
      end
      rsp.ready <= quiet || ($urandom_range(99) >= 37);
    end
  end

  // Queue up one item; the prediction runs when the driver takes it
  task automatic push_item(logic [1:0] op, int site, logic signed [23:0] lv,
                           logic signed [15:0] sd, logic [15:0] ad);
    lmu_tb_pkg::site_req_t it;
    it.op = op;
    it.site_index = 4'(site);
    it.load_value = lv;
    it.step_draw = sd;
    it.accept_draw = ad;
    pending_q = {pending_q, it};
  endtask

  // Hold until every queued item has been answered, then let the core settle
  task automatic drain;
    while (pending_q.size() > 0 || expected_q.size() > 0 || req.valid) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write one register; only called while the block is idle
  task automatic write_reg(logic [1:0] index, logic [23:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (index)
      lmu_pkg::REG_STEP_SIZE:  pr_step  = data[15:0];
      lmu_pkg::REG_QUAD_COEFF: pr_quad  = data;
      default:                 pr_quart = data;
    endcase
  endtask

  // Random site value: mostly moderate, sometimes any 24-bit value
  function automatic logic signed [23:0] rand_value();
    if ($urandom_range(9) == 0) return 24'($urandom);
    return 24'(int'($urandom_range(2 * 262144)) - 262144);
  endfunction

  function automatic logic [15:0] rand_accept();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // A phase of random work; the lattice is already fully loaded
  task automatic random_phase(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 70)
        push_item(lmu_pkg::OP_UPDATE, $urandom_range(SITES - 1), 24'($urandom),
                  16'($urandom), rand_accept());
      else if (r < 80)
        push_item(lmu_pkg::OP_LOAD, $urandom_range(SITES - 1), rand_value(),
                  16'($urandom), 16'($urandom));
      else
        // the spare op acts as a read
        push_item(($urandom_range(1) == 0) ? lmu_pkg::OP_READ : lmu_tb_pkg::OP_SPARE,
                  $urandom_range(SITES - 1), 24'($urandom), 16'($urandom),
                  16'($urandom));
    end
  endtask

  initial begin
    // Drive every input to a known level from time zero
    req.valid = 1'b0; req.op = lmu_pkg::OP_READ; req.site_index = '0;
    req.load_value = '0; req.step_draw = '0; req.accept_draw = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0; cfg.index = lmu_pkg::REG_STEP_SIZE; cfg.data = '0;
    pr_step = lmu_pkg::STEP_SIZE_RESET;
    pr_quad = lmu_pkg::QUAD_RESET;
    pr_quart = lmu_pkg::QUART_RESET;
    foreach (site_mem[i]) site_mem[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: load every site before any update, extremes included
    for (int s = 0; s < SITES; s++)
      push_item(lmu_pkg::OP_LOAD, s, (s == 0) ? 24'sh7FFFFF : (s == 1) ? -24'sd8388608 :
                24'(s * 4096 - 30000), 16'($urandom), 16'($urandom));
    push_item(lmu_pkg::OP_READ, 0, 24'sd0, 16'sd0, 16'd0);
    push_item(lmu_tb_pkg::OP_SPARE, 1, 24'sd0, 16'sd0, 16'd0);
    // saturate upward and downward, steps at both extremes
    push_item(lmu_pkg::OP_UPDATE, 0, 24'sd0, 16'sh7FFF, 16'hFFFF);
    push_item(lmu_pkg::OP_UPDATE, 1, 24'sd0, -16'sd32768, 16'hFFFF);
    push_item(lmu_pkg::OP_UPDATE, 5, 24'sd0, -16'sd32768, 16'd0);
    push_item(lmu_pkg::OP_UPDATE, 6, 24'sd0, 16'sd0, 16'hFFFF);
    push_item(lmu_pkg::OP_UPDATE, 7, 24'sd0, 16'sh7FFF, 16'd1);
    push_item(lmu_pkg::OP_UPDATE, 15, 24'sd0, 16'sd1234, 16'h8000);
    drain();

    // Random phases across several register settings, extremes among them
    quiet = 1'b1;
    random_phase(120);
    drain();
    quiet = 1'b0;
    random_phase(250);
    drain();
    write_reg(lmu_pkg::REG_STEP_SIZE, 24'hFFFF);
    write_reg(lmu_pkg::REG_QUAD_COEFF, 24'h7FFFFF);
    write_reg(lmu_pkg::REG_QUART_COEFF, 24'h800000);
    random_phase(150);
    drain();
    write_reg(lmu_pkg::REG_STEP_SIZE, 24'd0);
    write_reg(lmu_pkg::REG_QUAD_COEFF, 24'h800000);
    write_reg(lmu_pkg::REG_QUART_COEFF, 24'h7FFFFF);
    random_phase(100);
    drain();
    write_reg(lmu_pkg::REG_STEP_SIZE, 24'd300);
    write_reg(lmu_pkg::REG_QUAD_COEFF, 24'($urandom));
    write_reg(lmu_pkg::REG_QUART_COEFF, 24'd0);
    random_phase(150);
    drain();
    write_reg(lmu_pkg::REG_STEP_SIZE, 24'd4000);
    write_reg(lmu_pkg::REG_QUAD_COEFF, 24'hFE0000);
    write_reg(lmu_pkg::REG_QUART_COEFF, 24'd1000);
    random_phase(200);
    drain();
    repeat (50) @(posedge clk);

    $display("Covered %0d responses, %0d updates of which %0d accepted.",
             n_results, n_updates, n_accepts);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
